@@ src/sv39ptw_pkg.sv @@
// Shared types, constants and codes for the Sv39 page table walker.
package sv39ptw_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_STORE_PAGES   = 16;
    localparam int DEF_VA_LIMIT_BITS = 38;

    // Fixed Sv39 geometry
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int VPN_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_OFS_W        = 12;
    localparam int VA_W              = 64;
    localparam int PTE_W             = 64;
    localparam int PPN_W             = 44;
    localparam int PPA_W             = PPN_W + PAGE_OFS_W;
    localparam int FLAG_W            = 10;
    localparam int PTE_PPN_LSB       = 10;
    localparam int WORD_IDX_W        = 13;
    localparam int CFG_IDX_W         = 1;

    // Virtual page number fields per level
    localparam int VPN0_LSB = PAGE_OFS_W;
    localparam int VPN1_LSB = PAGE_OFS_W + VPN_W;
    localparam int VPN2_LSB = PAGE_OFS_W + 2 * VPN_W;

    // PTE flag bit positions
    localparam int PTE_V_BIT = 0;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_U_BIT = 4;

    // Item operations
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_VA_HIGH      = 3'd1,
        ST_PTR_INVALID  = 3'd2,
        ST_LEAF_INVALID = 3'd3,
        ST_NOT_USER     = 3'd4,
        ST_NOT_WRITE    = 3'd5,
        ST_OUTSIDE      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_L2,
        WS_L1,
        WS_L0
    } t_walk_state;

    typedef struct packed {
        logic [PPN_W-1:0] root_page;
        logic [PPN_W-1:0] store_base;
    } t_cfg;

    typedef struct packed {
        logic [PPA_W-1:0]  ppa;
        logic [FLAG_W-1:0] flags;
        t_status           status;
    } t_result;

endpackage

@@ src/sv39_page_table_walker_top.sv @@
// Top level of the Sv39 page table walker: configuration registers, walker and table store.
//
// Sv39 page table walker over a local table store of STORE_PAGES pages of 512
// 64-bit words. A request is accepted at a rising edge with start high and busy
// low. A write request loads one table word (indexes beyond the store are
// dropped); a translate request walks levels 2, 1 and 0 and returns the leaf's
// page-aligned physical address, its low ten flag bits and a status code. Each
// result is shown for exactly one cycle with o_result_valid high and must be
// taken then: the receiver cannot stall the block, and nothing is buffered.
// Timing: write requests and translates that fault before any table read
// (address at or above 2^VA_LIMIT_BITS, root page outside the store) give
// their result in the cycle after acceptance and keep busy low, so one such
// request can be taken every cycle. A translate that reads the store holds
// busy high while it steps through the level states L2, L1 and L0, reading
// one level's entry in each and stopping early on a fault, since each level's
// address comes from the previous entry out of the single-read-port synchronous
// store. A full walk registers its result on leaving L0, a walk that stops at
// the level-2 or level-1 entry on leaving L2 or L1; no new request is taken
// until the walk is back in idle. After reset the store is swept to zero, one
// word a cycle, through all STORE_PAGES * 512 words (8192 with the default);
// busy stays high throughout. Configuration writes are taken in any cycle,
// including during the sweep, and are meant to be done only while no walk is
// in flight.
module sv39_page_table_walker_top #(
    parameter int STORE_PAGES   = sv39ptw_pkg::DEF_STORE_PAGES,
    parameter int VA_LIMIT_BITS = sv39ptw_pkg::DEF_VA_LIMIT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sv39ptw_pkg::PPN_W-1:0]       i_cfg_data,
    // Request channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [sv39ptw_pkg::WORD_IDX_W-1:0]  i_word_index,
    input  logic [sv39ptw_pkg::PTE_W-1:0]       i_word_data,
    input  logic [sv39ptw_pkg::VA_W-1:0]        i_virtual_address,
    input  logic                                i_need_user,
    input  logic                                i_need_write,
    // Result channel
    output logic                                o_result_valid,
    output logic [sv39ptw_pkg::PPA_W-1:0]       o_physical_page_address,
    output logic [sv39ptw_pkg::FLAG_W-1:0]      o_leaf_flags,
    output logic [2:0]                          o_status
);

    localparam int STORE_WORDS = STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    sv39ptw_pkg::t_cfg             r_cfg;
    sv39ptw_pkg::t_result          w_res;
    logic                          w_clearing;
    logic                          w_wr_en;
    logic [ADDR_W-1:0]             w_wr_addr;
    logic [sv39ptw_pkg::PTE_W-1:0] w_wr_data;
    logic                          w_rd_en;
    logic [ADDR_W-1:0]             w_rd_addr;
    logic [sv39ptw_pkg::PTE_W-1:0] w_rd_data;

    // Configuration registers: both reset to page zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sv39ptw_pkg::CFG_ROOT_PAGE: begin
                    r_cfg.root_page <= i_cfg_data;
                end
                sv39ptw_pkg::CFG_STORE_BASE: begin
                    r_cfg.store_base <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    sv39ptw_walk #(
        .STORE_PAGES   (STORE_PAGES),
        .VA_LIMIT_BITS (VA_LIMIT_BITS)
    ) u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_start           (start),
        .o_busy            (busy),
        .i_operation       (i_operation),
        .i_word_index      (i_word_index),
        .i_word_data       (i_word_data),
        .i_virtual_address (i_virtual_address),
        .i_need_user       (i_need_user),
        .i_need_write      (i_need_write),
        .i_clearing        (w_clearing),
        .o_wr_en           (w_wr_en),
        .o_wr_addr         (w_wr_addr),
        .o_wr_data         (w_wr_data),
        .o_rd_en           (w_rd_en),
        .o_rd_addr         (w_rd_addr),
        .i_rd_data         (w_rd_data),
        .o_res_valid       (o_result_valid),
        .o_res             (w_res)
    );

    sv39ptw_store #(
        .STORE_PAGES (STORE_PAGES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    assign o_physical_page_address = w_res.ppa;
    assign o_leaf_flags            = w_res.flags;
    assign o_status                = 3'(w_res.status);

endmodule

@@ src/sv39ptw_store.sv @@
// Page table store: single synchronous memory with a clearing sweep after reset.
module sv39ptw_store #(
    parameter int STORE_PAGES = sv39ptw_pkg::DEF_STORE_PAGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE)-1:0] i_wr_addr,
    input  logic [sv39ptw_pkg::PTE_W-1:0]  i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE)-1:0] i_rd_addr,
    output logic [sv39ptw_pkg::PTE_W-1:0]  o_rd_data,
    output logic                           o_clearing
);

    localparam int STORE_WORDS = STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    logic [sv39ptw_pkg::PTE_W-1:0] r_mem [STORE_WORDS];
    logic [sv39ptw_pkg::PTE_W-1:0] r_rd_data;
    logic                          r_clearing;
    logic [ADDR_W-1:0]             r_clr_addr;

    // Sweep one word per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

@@ src/sv39ptw_walk.sv @@
// Walk sequencer: item decode, per-level lookup addressing, leaf checks and result register.
module sv39ptw_walk #(
    parameter int STORE_PAGES   = sv39ptw_pkg::DEF_STORE_PAGES,
    parameter int VA_LIMIT_BITS = sv39ptw_pkg::DEF_VA_LIMIT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sv39ptw_pkg::t_cfg                   i_cfg,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_operation,
    input  logic [sv39ptw_pkg::WORD_IDX_W-1:0]  i_word_index,
    input  logic [sv39ptw_pkg::PTE_W-1:0]       i_word_data,
    input  logic [sv39ptw_pkg::VA_W-1:0]        i_virtual_address,
    input  logic                                i_need_user,
    input  logic                                i_need_write,
    input  logic                                i_clearing,
    output logic                                o_wr_en,
    output logic [$clog2(STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE)-1:0] o_wr_addr,
    output logic [sv39ptw_pkg::PTE_W-1:0]       o_wr_data,
    output logic                                o_rd_en,
    output logic [$clog2(STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE)-1:0] o_rd_addr,
    input  logic [sv39ptw_pkg::PTE_W-1:0]       i_rd_data,
    output logic                                o_res_valid,
    output sv39ptw_pkg::t_result                o_res
);

    localparam int STORE_WORDS = STORE_PAGES * sv39ptw_pkg::ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int PAGE_W      = $clog2(STORE_PAGES);
    localparam int VPN_W       = sv39ptw_pkg::VPN_W;
    localparam int PPN_W       = sv39ptw_pkg::PPN_W;
    localparam int CMP_W       = (ADDR_W + 1 > sv39ptw_pkg::WORD_IDX_W) ?
                                 ADDR_W + 1 : sv39ptw_pkg::WORD_IDX_W;

    sv39ptw_pkg::t_walk_state r_state, n_state;
    logic [2*VPN_W-1:0]       r_vpn_lo;
    logic                     r_need_user;
    logic                     r_need_write;
    logic                     r_res_valid, n_res_valid;
    sv39ptw_pkg::t_result     r_res, n_res;

    logic                     w_accept;
    logic                     w_va_high;
    logic [PPN_W-1:0]         w_lk_page;
    logic [VPN_W-1:0]         w_lk_idx;
    logic [PPN_W-1:0]         w_rel;
    logic                     w_inside;
    logic                     w_entry_v;

    assign o_busy    = i_clearing || (r_state != sv39ptw_pkg::WS_IDLE);
    assign w_accept  = i_start && !o_busy;
    assign w_va_high = |i_virtual_address[sv39ptw_pkg::VA_W-1:VA_LIMIT_BITS];
    assign w_entry_v = i_rd_data[sv39ptw_pkg::PTE_V_BIT];

    // Pick the table page and index of the next lookup
    always_comb begin
        w_lk_page = '0;
        w_lk_idx  = '0;
        case (r_state)
            sv39ptw_pkg::WS_IDLE: begin
                w_lk_page = i_cfg.root_page;
                w_lk_idx  = i_virtual_address[sv39ptw_pkg::VPN2_LSB +: VPN_W];
            end
            sv39ptw_pkg::WS_L2: begin
                w_lk_page = i_rd_data[sv39ptw_pkg::PTE_PPN_LSB +: PPN_W];
                w_lk_idx  = r_vpn_lo[VPN_W +: VPN_W];
            end
            sv39ptw_pkg::WS_L1: begin
                w_lk_page = i_rd_data[sv39ptw_pkg::PTE_PPN_LSB +: PPN_W];
                w_lk_idx  = r_vpn_lo[0 +: VPN_W];
            end
            default: begin
                w_lk_page = '0;
                w_lk_idx  = '0;
            end
        endcase
    end

    // Page offset into the store wraps modulo 2^44
    assign w_rel     = w_lk_page - i_cfg.store_base;
    assign w_inside  = (w_rel < PPN_W'(STORE_PAGES));
    assign o_rd_addr = {w_rel[PAGE_W-1:0], w_lk_idx};

    // Table write goes straight to the store on accept
    assign o_wr_en   = w_accept && (i_operation == sv39ptw_pkg::OP_WRITE) &&
                       (CMP_W'(i_word_index) < CMP_W'(STORE_WORDS));
    assign o_wr_addr = ADDR_W'(i_word_index);
    assign o_wr_data = i_word_data;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sv39ptw_pkg::WS_IDLE: begin
                if (w_accept && (i_operation == sv39ptw_pkg::OP_TRANSLATE) &&
                    !w_va_high && w_inside) begin
                    n_state = sv39ptw_pkg::WS_L2;
                end
            end
            sv39ptw_pkg::WS_L2: begin
                n_state = (w_entry_v && w_inside) ? sv39ptw_pkg::WS_L1 : sv39ptw_pkg::WS_IDLE;
            end
            sv39ptw_pkg::WS_L1: begin
                n_state = (w_entry_v && w_inside) ? sv39ptw_pkg::WS_L0 : sv39ptw_pkg::WS_IDLE;
            end
            sv39ptw_pkg::WS_L0: begin
                n_state = sv39ptw_pkg::WS_IDLE;
            end
            default: begin
                n_state = sv39ptw_pkg::WS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rd_en     = 1'b0;
        n_res_valid = 1'b0;
        n_res       = '0;
        case (r_state)
            sv39ptw_pkg::WS_IDLE: begin
                if (w_accept) begin
                    if (i_operation == sv39ptw_pkg::OP_WRITE) begin
                        n_res_valid = 1'b1;
                    end else if (w_va_high) begin
                        n_res_valid  = 1'b1;
                        n_res.status = sv39ptw_pkg::ST_VA_HIGH;
                    end else if (!w_inside) begin
                        n_res_valid  = 1'b1;
                        n_res.status = sv39ptw_pkg::ST_OUTSIDE;
                    end else begin
                        o_rd_en = 1'b1;
                    end
                end
            end
            sv39ptw_pkg::WS_L2, sv39ptw_pkg::WS_L1: begin
                if (!w_entry_v) begin
                    n_res_valid  = 1'b1;
                    n_res.status = sv39ptw_pkg::ST_PTR_INVALID;
                end else if (!w_inside) begin
                    n_res_valid  = 1'b1;
                    n_res.status = sv39ptw_pkg::ST_OUTSIDE;
                end else begin
                    o_rd_en = 1'b1;
                end
            end
            sv39ptw_pkg::WS_L0: begin
                // Leaf: valid first, then user, then write
                n_res_valid = 1'b1;
                n_res.flags = i_rd_data[sv39ptw_pkg::FLAG_W-1:0];
                if (!w_entry_v) begin
                    n_res.status = sv39ptw_pkg::ST_LEAF_INVALID;
                end else if (r_need_user && !i_rd_data[sv39ptw_pkg::PTE_U_BIT]) begin
                    n_res.status = sv39ptw_pkg::ST_NOT_USER;
                end else if (r_need_write && !i_rd_data[sv39ptw_pkg::PTE_W_BIT]) begin
                    n_res.status = sv39ptw_pkg::ST_NOT_WRITE;
                end else begin
                    n_res.ppa = {i_rd_data[sv39ptw_pkg::PTE_PPN_LSB +: PPN_W],
                                 {sv39ptw_pkg::PAGE_OFS_W{1'b0}}};
                end
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sv39ptw_pkg::WS_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    // Hold the lower VPN fields and permission requests for the walk
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vpn_lo     <= i_virtual_address[sv39ptw_pkg::VPN0_LSB +: 2*VPN_W];
            r_need_user  <= i_need_user;
            r_need_write <= i_need_write;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ tb/sv39_page_table_walker_top_tb.sv @@
// Self-checking testbench for the Sv39 page table walker: table builds, walks and fault codes.
`timescale 1ns / 1ps

module sv39_page_table_walker_top_tb;
    import sv39ptw_pkg::*;

    localparam int STORE_PAGES = DEF_STORE_PAGES;
    localparam int STORE_WORDS = STORE_PAGES * ENTRIES_PER_TABLE;
    localparam int VA_LIMIT    = DEF_VA_LIMIT_BITS;
    // The sweep after reset plus every request at its worst gap and walk, several times over
    localparam int CYCLE_LIMIT = 200000;
    // Settle time after the last result, a little over one full walk
    localparam int WALK_CYCLES = 4;

    localparam logic [PPN_W-1:0]  PPN_MAX = '1;
    localparam logic [FLAG_W-1:0] FL_V    = FLAG_W'(1) << PTE_V_BIT;
    localparam logic [FLAG_W-1:0] FL_W    = FLAG_W'(1) << PTE_W_BIT;
    localparam logic [FLAG_W-1:0] FL_U    = FLAG_W'(1) << PTE_U_BIT;
    // V, R, W and X: a pointer with leaf-like bits, which the walk must ignore
    localparam logic [FLAG_W-1:0] FL_VRWX = 10'h00F;
    localparam logic [FLAG_W-1:0] FL_ALL  = '1;

    typedef struct packed {
        logic                  op;
        logic [WORD_IDX_W-1:0] idx;
        logic [PTE_W-1:0]      data;
        logic [VA_W-1:0]       va;
        logic                  need_user;
        logic                  need_write;
    } t_walk_request;

    // Mirror of the table store and registers; predicts and checks every result.
    class t_walk_checker;
        logic [PTE_W-1:0] table_words [STORE_WORDS];
        logic [PPN_W-1:0] root_page;
        logic [PPN_W-1:0] store_base;
        t_result          translation_q [$];
        int               errors;
        int               writes;
        int               translations;
        int               outcome_count [7];

        function new();
            foreach (table_words[i]) table_words[i] = '0;
            foreach (outcome_count[i]) outcome_count[i] = 0;
            root_page    = '0;
            store_base   = '0;
            errors       = 0;
            writes       = 0;
            translations = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [PPN_W-1:0] value);
            if (index == CFG_ROOT_PAGE) root_page = value;
            else store_base = value;
        endfunction

        // Apply a write and queue its empty result, or walk the three levels and queue the translation outcome.
        function void note_request(t_walk_request req);
            t_result          res;
            logic [PPN_W-1:0] page;
            logic [PPN_W-1:0] rel;
            logic [PTE_W-1:0] pte;
            int               lvl;
            int               vpn;
            bit               stopped;
            res     = '0;
            pte     = '0;
            stopped = 1'b0;
            if (req.op == OP_WRITE) begin
                if (int'(req.idx) < STORE_WORDS) table_words[req.idx] = req.data;
                writes++;
            end else begin
                translations++;
                if ((req.va >> VA_LIMIT) != 0) begin
                    res.status = ST_VA_HIGH;
                end else begin
                    page = root_page;
                    for (lvl = 2; lvl >= 0 && !stopped; lvl--) begin
                        // page offset from the store base wraps at 44 bits
                        rel = page - store_base;
                        vpn = int'((req.va >> (PAGE_OFS_W + VPN_W * lvl))
                                   & (ENTRIES_PER_TABLE - 1));
                        if (rel >= PPN_W'(STORE_PAGES)) begin
                            res.status = ST_OUTSIDE;
                            stopped    = 1'b1;
                        end else begin
                            pte = table_words[int'(rel) * ENTRIES_PER_TABLE + vpn];
                            if (lvl > 0) begin
                                if (!pte[PTE_V_BIT]) begin
                                    res.status = ST_PTR_INVALID;
                                    stopped    = 1'b1;
                                end else begin
                                    page = pte[PTE_PPN_LSB +: PPN_W];
                                end
                            end
                        end
                    end
                    if (!stopped) begin
                        res.flags = pte[FLAG_W-1:0];
                        if (!pte[PTE_V_BIT]) res.status = ST_LEAF_INVALID;
                        else if (req.need_user && !pte[PTE_U_BIT]) res.status = ST_NOT_USER;
                        else if (req.need_write && !pte[PTE_W_BIT]) res.status = ST_NOT_WRITE;
                        else res.ppa = {pte[PTE_PPN_LSB +: PPN_W], {PAGE_OFS_W{1'b0}}};
                    end
                end
                outcome_count[int'(res.status)]++;
            end
            translation_q.push_back(res);
        endfunction

        function void check_result(logic [PPA_W-1:0] ppa, logic [FLAG_W-1:0] flags,
                                   logic [2:0] status);
            t_result want;
            if (translation_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: ppa %h flags %h status %0d",
                         $time, ppa, flags, status);
                return;
            end
            want = translation_q.pop_front();
            if (ppa !== want.ppa) begin
                errors++;
                $display("%0t: physical page address expected %h, actual %h",
                         $time, want.ppa, ppa);
            end
            if (flags !== want.flags) begin
                errors++;
                $display("%0t: leaf flags expected %h, actual %h", $time, want.flags, flags);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            end
        endfunction

        function int pending();
            return translation_q.size();
        endfunction

        function void finish_check();
            if (translation_q.size() != 0) begin
                errors++;
                $display("%0t: %0d results never arrived", $time, translation_q.size());
            end
        endfunction
    endclass

    // Every input starts at a known value
    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index       = CFG_ROOT_PAGE;
    logic [PPN_W-1:0]       i_cfg_data        = '0;
    logic                   start             = 1'b0;
    logic                   busy;
    logic                   i_operation       = OP_WRITE;
    logic [WORD_IDX_W-1:0]  i_word_index      = '0;
    logic [PTE_W-1:0]       i_word_data       = '0;
    logic [VA_W-1:0]        i_virtual_address = '0;
    logic                   i_need_user       = 1'b0;
    logic                   i_need_write      = 1'b0;
    logic                   o_result_valid;
    logic [PPA_W-1:0]       o_physical_page_address;
    logic [FLAG_W-1:0]      o_leaf_flags;
    logic [2:0]             o_status;

    t_walk_checker     chk;
    logic [PPN_W-1:0]  stim_root;
    logic [PPN_W-1:0]  stim_base;
    logic [VA_W-1:0]   mapped_vas [$];
    bit                req_held;
    int                burst_left;
    int                settings_used;
    int                cycles = 0;

    sv39_page_table_walker_top u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .start                   (start),
        .busy                    (busy),
        .i_operation             (i_operation),
        .i_word_index            (i_word_index),
        .i_word_data             (i_word_data),
        .i_virtual_address       (i_virtual_address),
        .i_need_user             (i_need_user),
        .i_need_write            (i_need_write),
        .o_result_valid          (o_result_valid),
        .o_physical_page_address (o_physical_page_address),
        .o_leaf_flags            (o_leaf_flags),
        .o_status                (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be stalled: take each one in the cycle its strobe is high
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            chk.check_result(o_physical_page_address, o_leaf_flags, o_status);
    end

    // Watchdog: give up well past the slowest correct run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, chk.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [PTE_W-1:0] make_pte(logic [PPN_W-1:0] ppn,
                                                  logic [FLAG_W-1:0] flags);
        return {{(PTE_W - PPN_W - FLAG_W){1'b0}}, ppn, flags};
    endfunction

    function automatic logic [VA_W-1:0] make_va(int v2, int v1, int v0, int ofs);
        return (64'(v2) << VPN2_LSB) | (64'(v1) << VPN1_LSB) | (64'(v0) << VPN0_LSB)
               | 64'(ofs);
    endfunction

    // Valid pointer to a store page, with random reserved, flag and upper bits
    function automatic logic [PTE_W-1:0] pointer_to(int slot);
        logic [PTE_W-1:0] pte;
        pte                         = rand64();
        pte[PTE_PPN_LSB +: PPN_W]   = stim_base + PPN_W'(slot);
        pte[PTE_V_BIT]              = 1'b1;
        return pte;
    endfunction

    // Leaf with random target and flags, valid most of the time
    function automatic logic [PTE_W-1:0] leaf_word();
        logic [PTE_W-1:0] pte;
        pte            = rand64();
        pte[PTE_V_BIT] = ($urandom_range(0, 7) != 0);
        return pte;
    endfunction

    // Fill every field with noise; the operation decides which fields matter
    function automatic t_walk_request noise_request();
        t_walk_request r;
        r.op         = rand_bit();
        r.idx        = WORD_IDX_W'($urandom());
        r.data       = rand64();
        r.va         = rand64();
        r.need_user  = rand_bit();
        r.need_write = rand_bit();
        return r;
    endfunction

    // Hold the request until the block takes it, then idle at burst ends.
    task automatic send_request(input t_walk_request req);
        int gap;
        start             <= 1'b1;
        i_operation       <= req.op;
        i_word_index      <= req.idx;
        i_word_data       <= req.data;
        i_virtual_address <= req.va;
        i_need_user       <= req.need_user;
        i_need_write      <= req.need_write;
        req_held = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        chk.note_request(req);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            req_held = 1'b0;
            // mostly short bursts, now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                              : $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_word(input int index, input logic [PTE_W-1:0] data);
        t_walk_request r;
        r      = noise_request();
        r.op   = OP_WRITE;
        r.idx  = WORD_IDX_W'(index);
        r.data = data;
        send_request(r);
    endtask

    task automatic translate(input logic [VA_W-1:0] va, input bit nu, input bit nw);
        t_walk_request r;
        r            = noise_request();
        r.op         = OP_TRANSLATE;
        r.va         = va;
        r.need_user  = nu;
        r.need_write = nw;
        send_request(r);
    endtask

    // Drop start and hold off until every result is back, then let the walk settle.
    task automatic wait_idle();
        if (req_held) begin
            start <= 1'b0;
            req_held = 1'b0;
        end
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (WALK_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back cycles; only called while idle.
    task automatic set_registers(input logic [PPN_W-1:0] root, input logic [PPN_W-1:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROOT_PAGE;
        i_cfg_data  <= root;
        @(posedge i_clk);
        chk.set_register(CFG_ROOT_PAGE, root);
        i_cfg_index <= CFG_STORE_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        chk.set_register(CFG_STORE_BASE, base);
        i_cfg_we <= 1'b0;
        stim_root = root;
        stim_base = base;
        settings_used++;
        @(posedge i_clk);
    endtask

    // Hand-built tables under the reset registers (root and base page zero).
    task automatic run_directed();
        // empty store: level-2 entry is zero
        translate(make_va(0, 0, 0, 0), 1'b0, 1'b0);
        // first address past the limit, all ones, and the last one below it
        translate(64'(1) << VA_LIMIT, 1'b0, 1'b0);
        translate('1, 1'b1, 1'b1);
        translate((64'(1) << VA_LIMIT) - 1, 1'b0, 1'b0);
        // root -> page 1 -> page 2; the root pointer carries R, W and X
        write_word(0, make_pte(1, FL_VRWX));
        write_word(1 * ENTRIES_PER_TABLE, make_pte(2, FL_V));
        write_word(2 * ENTRIES_PER_TABLE, make_pte(PPN_MAX, FL_ALL));
        translate(make_va(0, 0, 0, 12'hFFF), 1'b1, 1'b1);
        // valid leaf with neither user nor write
        write_word(2 * ENTRIES_PER_TABLE + 1, make_pte(44'h123, FL_V));
        translate(make_va(0, 0, 1, 0), 1'b1, 1'b0);
        translate(make_va(0, 0, 1, 0), 1'b0, 1'b1);
        translate(make_va(0, 0, 1, 0), 1'b0, 1'b0);
        // every flag but valid: invalid leaf wins over user and write
        write_word(2 * ENTRIES_PER_TABLE + 2, make_pte(5, FL_ALL & ~FL_V));
        translate(make_va(0, 0, 2, 0), 1'b1, 1'b1);
        // writable but not user: user is checked before write
        write_word(2 * ENTRIES_PER_TABLE + 3, make_pte(6, FL_V | FL_W));
        translate(make_va(0, 0, 3, 0), 1'b1, 1'b1);
        // empty level-1 entry
        translate(make_va(0, 5, 0, 0), 1'b0, 1'b0);
        // level-2 pointer just past the store, level-1 pointer at the top page number
        write_word(1, make_pte(PPN_W'(STORE_PAGES), FL_V));
        translate(make_va(1, 0, 0, 0), 1'b0, 1'b0);
        write_word(1 * ENTRIES_PER_TABLE + 1, make_pte(PPN_MAX, FL_V));
        translate(make_va(0, 1, 0, 0), 1'b0, 1'b0);
        // last page of the store, last word, all ones
        write_word(1 * ENTRIES_PER_TABLE + 2, make_pte(PPN_W'(STORE_PAGES - 1), FL_V | FL_U));
        write_word(STORE_WORDS - 1, '1);
        translate(make_va(0, 2, ENTRIES_PER_TABLE - 1, 0), 1'b1, 1'b1);
        translate(make_va(0, 2, ENTRIES_PER_TABLE - 2, 0), 1'b0, 1'b0);
    endtask

    // Mostly build a full three-level mapping and translate through it; mix in noise.
    task automatic random_phase(input int n);
        int               sent;
        int               choice;
        int               root_slot;
        int               v2;
        int               v1;
        int               v0;
        int               s1;
        int               s0;
        bit               drained;
        logic [VA_W-1:0]  va;
        logic [PPN_W-1:0] rel;
        rel       = stim_root - stim_base;
        root_slot = (rel < PPN_W'(STORE_PAGES)) ? int'(rel)
                                                : $urandom_range(0, STORE_PAGES - 1);
        sent      = 0;
        drained   = 1'b0;
        while (sent < n) begin
            // pause once per phase until the block has answered everything
            if (!drained && sent >= n / 2) begin
                wait_idle();
                drained = 1'b1;
            end
            choice = $urandom_range(0, 99);
            v2     = $urandom_range(0, (1 << (VA_LIMIT - VPN2_LSB)) - 1);
            v1     = $urandom_range(0, ENTRIES_PER_TABLE - 1);
            v0     = $urandom_range(0, ENTRIES_PER_TABLE - 1);
            s1     = $urandom_range(0, STORE_PAGES - 1);
            s0     = $urandom_range(0, STORE_PAGES - 1);
            if (choice < 50) begin
                write_word(root_slot * ENTRIES_PER_TABLE + v2, pointer_to(s1));
                write_word(s1 * ENTRIES_PER_TABLE + v1, pointer_to(s0));
                write_word(s0 * ENTRIES_PER_TABLE + v0, leaf_word());
                va = make_va(v2, v1, v0, $urandom_range(0, 4095));
                translate(va, rand_bit(), rand_bit());
                mapped_vas.push_back(va);
                if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
                sent += 4;
            end else if (choice < 70 && mapped_vas.size() != 0) begin
                translate(mapped_vas[$urandom_range(0, mapped_vas.size() - 1)],
                          rand_bit(), rand_bit());
                sent++;
            end else if (choice < 80) begin
                write_word($urandom_range(0, (1 << WORD_IDX_W) - 1), rand64());
                sent++;
            end else if (choice < 90) begin
                translate(rand64() & ((64'(1) << VA_LIMIT) - 1), rand_bit(), rand_bit());
                sent++;
            end else if (choice < 95) begin
                va = rand64();
                va[$urandom_range(VA_LIMIT, VA_W - 1)] = 1'b1;
                translate(va, rand_bit(), rand_bit());
                sent++;
            end else begin
                // broken chain: root entry points at a random page or has its valid bit cleared
                write_word(root_slot * ENTRIES_PER_TABLE + v2,
                           rand_bit() ? make_pte(PPN_W'(rand64()), FL_V)
                                      : rand64() & ~64'(FL_V));
                translate(make_va(v2, v1, v0, 0), rand_bit(), rand_bit());
                sent += 2;
            end
        end
    endtask

    initial begin
        logic [PPN_W-1:0] base;
        chk           = new();
        stim_root     = '0;
        stim_base     = '0;
        settings_used = 1;
        burst_left    = 1;
        req_held      = 1'b0;

        // Hold reset, then release it; the store sweep then keeps busy high a while
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        random_phase(120);

        // Store at the top of the page space: pointers wrap past zero
        wait_idle();
        set_registers(PPN_MAX - 1, PPN_MAX - 3);
        random_phase(120);

        // Root just below the store: every walk stops at once
        wait_idle();
        set_registers(PPN_MAX, '0);
        random_phase(30);

        // Both registers at their maximum
        wait_idle();
        set_registers(PPN_MAX, PPN_MAX);
        random_phase(120);

        // Root one page past the end of the store
        base = PPN_W'(rand64());
        wait_idle();
        set_registers(base + PPN_W'(STORE_PAGES), base);
        random_phase(30);

        // Random placements of the store and root
        base = PPN_W'(rand64());
        wait_idle();
        set_registers(base + PPN_W'($urandom_range(0, STORE_PAGES - 1)), base);
        random_phase(120);

        base = PPN_W'(rand64());
        wait_idle();
        set_registers(base + PPN_W'($urandom_range(0, STORE_PAGES - 1)), base);
        random_phase(100);

        wait_idle();
        repeat (2 * WALK_CYCLES) @(posedge i_clk);
        chk.finish_check();

        $display("Covered %0d requests (%0d table writes, %0d translations) under %0d settings",
                 chk.writes + chk.translations, chk.writes, chk.translations, settings_used);
        $display("Outcomes: ok %0d, high %0d, bad pointer %0d, bad leaf %0d, %0d %0d %0d",
                 chk.outcome_count[ST_OK], chk.outcome_count[ST_VA_HIGH],
                 chk.outcome_count[ST_PTR_INVALID], chk.outcome_count[ST_LEAF_INVALID],
                 chk.outcome_count[ST_NOT_USER], chk.outcome_count[ST_NOT_WRITE],
                 chk.outcome_count[ST_OUTSIDE]);
        if (chk.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
